/* design/utf8d_pkg.sv */
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types and constants shared by the UTF-8 byte decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned PEND_W = 2;

  localparam logic [CP_W-1:0] SURR_LO = CP_W'(24'h00D800);
  localparam logic [CP_W-1:0] SURR_HI = CP_W'(24'h00DFFF);
  localparam logic [CP_W-1:0] CP_MAX  = CP_W'(24'h10FFFF);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [PEND_W-1:0] pend_t;

  typedef enum logic [1:0] {
    ST_ACCEPT   = 2'd0,
    ST_REJECT   = 2'd1,
    ST_CONTINUE = 2'd2
  } status_t;

endpackage

/* design/utf8_byte_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_byte_decoder
// Incremental UTF-8 decoder that turns each input byte into one result.
// ----------------------------------------------------------------------------
//  Channel | Ports                                  | Direction
//  --------+----------------------------------------+----------
//  in      | in_valid, in_stall, in_byte            | sink
//  out     | out_valid, out_stall, out_status,      | source
//          | out_code_point                         |
//
// A byte is held in the input register, and its result in the result register,
// before the result transfer. A new byte can be taken in every cycle while the
// result channel does not stall. The decode logic between the two registers
// sets that rate.
// Reset clears the pending count, the accumulator and both valid flags.
// A stall on the result channel holds the result register and then the input
// register, and in_stall rises only when both are full.
// ----------------------------------------------------------------------------
module utf8_byte_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  utf8d_pkg::byte_t   in_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output utf8d_pkg::status_t out_status,
  output utf8d_pkg::cp_t     out_code_point
);
  import utf8d_pkg::*;

  logic    s1_valid_r;
  byte_t   s1_byte_r;
  pend_t   pending_r, pending_nxt;
  cp_t     acc_r, acc_nxt;
  logic    out_valid_r;
  status_t out_status_r, status_nxt;
  cp_t     out_cp_r, cp_nxt;
  logic    advance;
  logic    in_take;
  cp_t     shifted;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_code_point = out_cp_r;

  assign shifted = {acc_r[CP_W-7:0], s1_byte_r[5:0]};

  always_comb begin
    pending_nxt = pending_r;
    acc_nxt     = acc_r;
    status_nxt  = ST_CONTINUE;
    cp_nxt      = '0;
    if (pending_r == '0) begin
      priority if (s1_byte_r[7] == 1'b0) begin
        acc_nxt    = CP_W'(s1_byte_r);
        status_nxt = ST_ACCEPT;
        cp_nxt     = CP_W'(s1_byte_r);
      end else if (s1_byte_r[7:5] == 3'b110) begin
        acc_nxt     = CP_W'(s1_byte_r[4:0]);
        pending_nxt = PEND_W'(1);
      end else if (s1_byte_r[7:4] == 4'b1110) begin
        acc_nxt     = CP_W'(s1_byte_r[3:0]);
        pending_nxt = PEND_W'(2);
      end else if (s1_byte_r[7:3] == 5'b11110) begin
        acc_nxt     = CP_W'(s1_byte_r[2:0]);
        pending_nxt = PEND_W'(3);
      end else begin
        acc_nxt    = '0;
        status_nxt = ST_REJECT;
      end
    end else if (s1_byte_r[7:6] != 2'b10) begin
      acc_nxt     = '0;
      pending_nxt = '0;
      status_nxt  = ST_REJECT;
    end else if (pending_r != PEND_W'(1)) begin
      acc_nxt     = shifted;
      pending_nxt = pending_r - PEND_W'(1);
    end else if ((shifted >= SURR_LO && shifted <= SURR_HI) || shifted > CP_MAX) begin
      acc_nxt     = '0;
      pending_nxt = '0;
      status_nxt  = ST_REJECT;
    end else begin
      acc_nxt     = shifted;
      pending_nxt = '0;
      status_nxt  = ST_ACCEPT;
      cp_nxt      = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pending_r   <= '0;
      acc_r       <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        pending_r   <= pending_nxt;
        acc_r       <= acc_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_byte;
    end
    if (advance) begin
      out_status_r <= status_nxt;
      out_cp_r     <= cp_nxt;
    end
  end

  a_cp_zero_unless_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_ACCEPT |-> out_cp_r == '0)
    else $error("code point not zero on a non-accept result");

  a_cp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_ACCEPT |->
      out_cp_r <= CP_MAX && !(out_cp_r >= SURR_LO && out_cp_r <= SURR_HI))
    else $error("accepted code point out of range or surrogate");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(pending_r) && $stable(acc_r))
    else $error("decode state changed without a byte");

  a_reject_idles: assert property (@(posedge clk) disable iff (!rst_n)
    advance && status_nxt == ST_REJECT |=> pending_r == '0 && acc_r == '0)
    else $error("decoder not idle after a reject");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled while a register was free");

endmodule
